@@ rtl/cma_pkg.sv @@
// ----------------------------------------------------------------------------
// cma_pkg
// Shared constants, command and status types and the month length table
// for the calendar minute advance block.
// ----------------------------------------------------------------------------
`default_nettype none

package cma_pkg;

  localparam int unsigned ElapsedWidth = 17;
  localparam int unsigned RemWidth     = 18;
  localparam int unsigned YearWidth    = 14;
  localparam int unsigned MonthWidth   = 4;
  localparam int unsigned DayWidth     = 5;
  localparam int unsigned HourWidth    = 5;
  localparam int unsigned MinuteWidth  = 6;
  localparam int unsigned ModWidth     = 11;
  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 14;
  localparam int unsigned InTdataWidth  = 24;
  localparam int unsigned OutTdataWidth = 48;

  localparam logic [CfgIdxWidth-1:0] CFG_BOOT_YEAR   = 3'd0;
  localparam logic [CfgIdxWidth-1:0] CFG_BOOT_MONTH  = 3'd1;
  localparam logic [CfgIdxWidth-1:0] CFG_BOOT_DAY    = 3'd2;
  localparam logic [CfgIdxWidth-1:0] CFG_BOOT_HOUR   = 3'd3;
  localparam logic [CfgIdxWidth-1:0] CFG_BOOT_MINUTE = 3'd4;

  localparam logic [YearWidth-1:0]   YEAR_RESET    = 14'd2026;
  localparam logic [YearWidth-1:0]   YEAR_MAX_BOOT = 14'd9998;
  localparam logic [YearWidth-1:0]   GREG_CYCLE    = 14'd400;
  localparam logic [MonthWidth-1:0]  MONTH_FEB     = 4'd2;
  localparam logic [MonthWidth-1:0]  MONTH_DEC     = 4'd12;
  localparam logic [HourWidth-1:0]   HOUR_LAST     = 5'd23;
  localparam logic [MinuteWidth-1:0] MINUTE_LAST   = 6'd59;
  localparam logic [RemWidth-1:0]    MIN_PER_HOUR  = 18'd60;

  typedef struct packed {
    logic load;
    logic mod_step;
    logic clamp;
    logic run_step;
    logic out_load;
  } cma_cmd_t;

  typedef struct packed {
    logic mod_ge;
    logic rem_ge;
  } cma_sts_t;

  function automatic logic [DayWidth-1:0] month_days(logic [MonthWidth-1:0] mo, logic leap);
    logic [DayWidth-1:0] d;
    unique case (mo)
      4'd2:    d = leap ? 5'd29 : 5'd28;
      4'd4:    d = 5'd30;
      4'd6:    d = 5'd30;
      4'd9:    d = 5'd30;
      4'd11:   d = 5'd30;
      default: d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

@@ rtl/calendar_minute_advance_core.sv @@
// ----------------------------------------------------------------------------
// calendar_minute_advance_core
// Turns minutes since boot into the current date, time and minute of day.
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel writes the boot date and time (index 0 year, 1 month,
//   2 day, 3 hour, 4 minute); cfg_ready_o is always high. Write only while
//   the block is idle. Boot values out of range are saturated before use.
//   s_axis carries one word of elapsed minutes; m_axis returns one word of
//   date and time for each input word, in order.
//   Each word passes load, the year cycle reduction, the day clamp and
//   the hour steps of the date counter, one hour per cycle. One word is in
//   work at a time; the next word is taken once the current one has
//   reached the output register. Reset restores boot 2026-01-01 00:00 and
//   empties the output register. While m_axis_tready is low the result
//   word holds in the output register; a new input word is still taken
//   and computed, then waits for the slot.
// ----------------------------------------------------------------------------
`default_nettype none

module calendar_minute_advance_core (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [cma_pkg::CfgIdxWidth-1:0]     cfg_index_i,
  input  wire logic [cma_pkg::CfgDataWidth-1:0]    cfg_data_i,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // elapsed_minutes[16:0], zero [23:17]
  input  wire logic [cma_pkg::InTdataWidth-1:0]    s_axis_tdata,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // cur_year[13:0], cur_month[17:14], cur_day[22:18], cur_hour[27:23],
  // cur_minute[33:28], minute_of_day[44:34], zero [47:45]
  output logic [cma_pkg::OutTdataWidth-1:0]        m_axis_tdata
);
  import cma_pkg::*;

  cma_cmd_t cmd;
  cma_sts_t sts;

  assign cfg_ready_o = 1'b1;

  cma_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cma_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .elapsed_i   (s_axis_tdata[ElapsedWidth-1:0]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (m_axis_tdata)
  );

endmodule

`default_nettype wire

@@ rtl/cma_ctrl.sv @@
// ----------------------------------------------------------------------------
// cma_ctrl
// Sequencer: load, year cycle reduction, day clamp, hour stepping and
// hand-off to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cma_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              out_ready_i,
  output logic                   out_valid_o,
  input  wire cma_pkg::cma_sts_t sts_i,
  output cma_pkg::cma_cmd_t      cmd_o
);
  import cma_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_CLAMP,
    ST_RUN,
    ST_FIN
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.mod_step = (state_q == ST_MOD) && sts_i.mod_ge;
    cmd_o.clamp    = (state_q == ST_CLAMP);
    cmd_o.run_step = (state_q == ST_RUN) && sts_i.rem_ge;
    cmd_o.out_load = (state_q == ST_FIN) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) state_q <= ST_MOD;
        end
        ST_MOD: begin
          if (!sts_i.mod_ge) state_q <= ST_CLAMP;
        end
        ST_CLAMP: begin
          state_q <= ST_RUN;
        end
        ST_RUN: begin
          if (!sts_i.rem_ge) state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_fin_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && !sts_i.rem_ge) |=> (state_q == ST_FIN))
    else $error("hour stepping did not hand off");
  a_valid_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FIN))
    else $error("result raised outside hand-off");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !cmd_o.out_load)
    else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire

@@ rtl/cma_dp.sv @@
// ----------------------------------------------------------------------------
// cma_dp
// Datapath: boot registers, date and time counters, remaining minute
// count and the output word register.
// ----------------------------------------------------------------------------
`default_nettype none

module cma_dp (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [cma_pkg::CfgIdxWidth-1:0]     cfg_index_i,
  input  wire logic [cma_pkg::CfgDataWidth-1:0]    cfg_data_i,
  input  wire logic [cma_pkg::ElapsedWidth-1:0]    elapsed_i,
  input  wire cma_pkg::cma_cmd_t                   cmd_i,
  output cma_pkg::cma_sts_t                        sts_o,
  output logic [cma_pkg::OutTdataWidth-1:0]        out_data_o
);
  import cma_pkg::*;

  logic [YearWidth-1:0]   boot_year_q;
  logic [MonthWidth-1:0]  boot_month_q;
  logic [DayWidth-1:0]    boot_day_q;
  logic [HourWidth-1:0]   boot_hour_q;
  logic [MinuteWidth-1:0] boot_minute_q;

  logic [YearWidth-1:0]   year_q, mod_q;
  logic [MonthWidth-1:0]  month_q;
  logic [DayWidth-1:0]    day_q;
  logic [HourWidth-1:0]   hour_q;
  logic [RemWidth-1:0]    rem_q;
  logic [OutTdataWidth-1:0] out_q;

  logic [YearWidth-1:0]   year_sat;
  logic [MonthWidth-1:0]  month_sat;
  logic [HourWidth-1:0]   hour_sat;
  logic [MinuteWidth-1:0] minute_sat;
  logic                   leap;
  logic [DayWidth-1:0]    dim;
  logic [ModWidth-1:0]    mod_day;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      boot_year_q   <= YEAR_RESET;
      boot_month_q  <= 4'd1;
      boot_day_q    <= 5'd1;
      boot_hour_q   <= 5'd0;
      boot_minute_q <= 6'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_BOOT_YEAR:   boot_year_q   <= cfg_data_i;
        CFG_BOOT_MONTH:  boot_month_q  <= cfg_data_i[MonthWidth-1:0];
        CFG_BOOT_DAY:    boot_day_q    <= cfg_data_i[DayWidth-1:0];
        CFG_BOOT_HOUR:   boot_hour_q   <= cfg_data_i[HourWidth-1:0];
        CFG_BOOT_MINUTE: boot_minute_q <= cfg_data_i[MinuteWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (boot_year_q == '0)               year_sat = 14'd1;
    else if (boot_year_q > YEAR_MAX_BOOT) year_sat = YEAR_MAX_BOOT;
    else                                  year_sat = boot_year_q;
    if (boot_month_q == '0)              month_sat = 4'd1;
    else if (boot_month_q > MONTH_DEC)   month_sat = MONTH_DEC;
    else                                  month_sat = boot_month_q;
    hour_sat   = (boot_hour_q > HOUR_LAST) ? HOUR_LAST : boot_hour_q;
    minute_sat = (boot_minute_q > MINUTE_LAST) ? MINUTE_LAST : boot_minute_q;
  end

  assign leap = (mod_q == '0) ||
                ((year_q[1:0] == 2'd0) && (mod_q != 14'd100) &&
                 (mod_q != 14'd200) && (mod_q != 14'd300));
  assign dim     = month_days(month_q, leap);
  assign mod_day = ModWidth'(hour_q) * 11'd60 + ModWidth'(rem_q[MinuteWidth-1:0]);

  assign sts_o.mod_ge = (mod_q >= GREG_CYCLE);
  assign sts_o.rem_ge = (rem_q >= MIN_PER_HOUR);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      year_q  <= year_sat;
      mod_q   <= year_sat;
      month_q <= month_sat;
      day_q   <= boot_day_q;
      hour_q  <= hour_sat;
      rem_q   <= RemWidth'(elapsed_i) + RemWidth'(minute_sat);
    end
    if (cmd_i.mod_step) begin
      mod_q <= mod_q - GREG_CYCLE;
    end
    if (cmd_i.clamp) begin
      if (day_q == '0)     day_q <= 5'd1;
      else if (day_q > dim) day_q <= dim;
    end
    if (cmd_i.run_step) begin
      rem_q <= rem_q - MIN_PER_HOUR;
      if (hour_q == HOUR_LAST) begin
        hour_q <= '0;
        if (day_q >= dim) begin
          day_q <= 5'd1;
          if (month_q == MONTH_DEC) begin
            month_q <= 4'd1;
            year_q  <= year_q + 14'd1;
            mod_q   <= (mod_q == GREG_CYCLE - 14'd1) ? '0 : mod_q + 14'd1;
          end else begin
            month_q <= month_q + 4'd1;
          end
        end else begin
          day_q <= day_q + 5'd1;
        end
      end else begin
        hour_q <= hour_q + 5'd1;
      end
    end
    if (cmd_i.out_load) begin
      out_q <= {3'd0, mod_day, rem_q[MinuteWidth-1:0], hour_q, day_q, month_q, year_q};
    end
  end

  assign out_data_o = out_q;

`ifndef SYNTHESIS
  a_day_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.run_step |-> (day_q >= 5'd1 && day_q <= dim))
    else $error("day outside month");
  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.run_step |-> (month_q >= 4'd1 && month_q <= MONTH_DEC && hour_q <= HOUR_LAST))
    else $error("month or hour out of range");
  a_cycle_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clamp |-> (mod_q < GREG_CYCLE && mod_q[1:0] == year_q[1:0]))
    else $error("year cycle position wrong");
`endif

endmodule

`default_nettype wire

@@ dv/tb_calendar_minute_advance_core.sv @@
// ----------------------------------------------------------------------------
// tb_calendar_minute_advance_core
// Self-checking bench for the calendar minute advance core: boot settings
// go in over the config channel while the core is idle, words of elapsed
// minutes stream in with random gaps, none in burst mode, and each output
// word is compared field by field against a date advanced in the bench.
// ----------------------------------------------------------------------------
module tb_calendar_minute_advance_core;
  timeunit 1ns;
  timeprecision 1ps;

  import cma_pkg::*;

  localparam logic [CfgIdxWidth-1:0] CFG_NONE_LO = 3'd5;
  localparam logic [CfgIdxWidth-1:0] CFG_NONE_HI = 3'd7;
  localparam int unsigned MAX_ELAPSED  = 71582;
  localparam int unsigned CYCLE_LIMIT  = 5_000_000;
  localparam int unsigned HOLD_CYCLES  = 6000;
  localparam int unsigned HOLD_AFTER   = 150;
  localparam int unsigned TAIL_CYCLES  = 2300;
  localparam int unsigned RAND_PHASES  = 5;
  localparam int unsigned PHASE_WORDS  = 100;

  typedef struct {
    logic [YearWidth-1:0]   year;
    logic [MonthWidth-1:0]  month;
    logic [DayWidth-1:0]    day;
    logic [HourWidth-1:0]   hour;
    logic [MinuteWidth-1:0] minute;
    logic [ModWidth-1:0]    mod;
  } cal_word_t;

  logic                     clk_i;
  logic                     rst_ni        = 1'b0;
  logic                     cfg_valid_i   = 1'b0;
  logic                     cfg_ready_o;
  logic [CfgIdxWidth-1:0]   cfg_index_i   = '0;
  logic [CfgDataWidth-1:0]  cfg_data_i    = '0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [InTdataWidth-1:0]  s_axis_tdata  = '0;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [OutTdataWidth-1:0] m_axis_tdata;

  logic [YearWidth-1:0]   boot_year_q   = YEAR_RESET;
  logic [MonthWidth-1:0]  boot_month_q  = 4'd1;
  logic [DayWidth-1:0]    boot_day_q    = 5'd1;
  logic [HourWidth-1:0]   boot_hour_q   = 5'd0;
  logic [MinuteWidth-1:0] boot_minute_q = 6'd0;

  logic [ElapsedWidth-1:0] pend_elapsed_q[$];
  cal_word_t               date_exp_q[$];

  logic [ElapsedWidth-1:0] cur_elapsed = '0;
  logic                    offering    = 1'b0;
  int unsigned             send_gap    = 0;
  int unsigned             recv_gap    = 0;
  logic                    burst_mode  = 1'b0;
  logic                    hold_off    = 1'b0;
  int unsigned             n_sent      = 0;
  int unsigned             n_checked   = 0;
  int unsigned             n_settings  = 0;
  int unsigned             err_cnt     = 0;
  int unsigned             cycle_cnt   = 0;

  calendar_minute_advance_core dut (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic bit is_leap(input int unsigned y);
    if ((y % 400) == 0) return 1'b1;
    if ((y % 100) == 0) return 1'b0;
    return (y % 4) == 0;
  endfunction

  function automatic int unsigned days_in_month(input int unsigned y, input int unsigned mo);
    case (mo)
      2:             return is_leap(y) ? 29 : 28;
      4, 6, 9, 11:   return 30;
      default:       return 31;
    endcase
  endfunction

  function automatic cal_word_t advance_date(input logic [ElapsedWidth-1:0] add);
    int unsigned y, mo, d, h, m, t, days;
    cal_word_t   r;
    y  = boot_year_q;
    mo = boot_month_q;
    d  = boot_day_q;
    h  = boot_hour_q;
    m  = boot_minute_q;
    if (y < 1) y = 1;
    if (y > YEAR_MAX_BOOT) y = YEAR_MAX_BOOT;
    if (mo < 1) mo = 1;
    if (mo > 12) mo = 12;
    if (d < 1) d = 1;
    if (d > days_in_month(y, mo)) d = days_in_month(y, mo);
    if (h > HOUR_LAST) h = HOUR_LAST;
    if (m > MINUTE_LAST) m = MINUTE_LAST;
    t    = m + add;
    m    = t % 60;
    t    = h + t / 60;
    h    = t % 24;
    days = t / 24;
    while (days > 0) begin
      days--;
      d++;
      if (d > days_in_month(y, mo)) begin
        d = 1;
        mo++;
        if (mo > 12) begin
          mo = 1;
          y++;
        end
      end
    end
    r.year   = YearWidth'(y);
    r.month  = MonthWidth'(mo);
    r.day    = DayWidth'(d);
    r.hour   = HourWidth'(h);
    r.minute = MinuteWidth'(m);
    r.mod    = ModWidth'(h * 60 + m);
    return r;
  endfunction

  function automatic logic [ElapsedWidth-1:0] draw_elapsed();
    case ($urandom_range(0, 9))
      0:       return ElapsedWidth'($urandom());
      1:       return ElapsedWidth'(1440 * $urandom_range(1, 49) - $urandom_range(0, 1));
      default: return ElapsedWidth'($urandom_range(0, MAX_ELAPSED));
    endcase
  endfunction

  task automatic write_boot_reg(input logic [CfgIdxWidth-1:0] idx,
                                input logic [CfgDataWidth-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_BOOT_YEAR:   boot_year_q   = val[YearWidth-1:0];
      CFG_BOOT_MONTH:  boot_month_q  = val[MonthWidth-1:0];
      CFG_BOOT_DAY:    boot_day_q    = val[DayWidth-1:0];
      CFG_BOOT_HOUR:   boot_hour_q   = val[HourWidth-1:0];
      CFG_BOOT_MINUTE: boot_minute_q = val[MinuteWidth-1:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_boot(input int unsigned y, input int unsigned mo, input int unsigned d,
                          input int unsigned h, input int unsigned mi);
    write_boot_reg(CFG_BOOT_YEAR,   CfgDataWidth'(y));
    write_boot_reg(CFG_BOOT_MONTH,  CfgDataWidth'(mo));
    write_boot_reg(CFG_BOOT_DAY,    CfgDataWidth'(d));
    write_boot_reg(CFG_BOOT_HOUR,   CfgDataWidth'(h));
    write_boot_reg(CFG_BOOT_MINUTE, CfgDataWidth'(mi));
    n_settings++;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pend_elapsed_q.size() != 0 || offering || date_exp_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic check_field(input string fname, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
      err_cnt++;
    end
  endtask

  // input side: pull from the pending queue, predict on acceptance
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      offering = 1'b0;
      send_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        date_exp_q.push_back(advance_date(cur_elapsed));
        n_sent++;
        offering = 1'b0;
        send_gap = burst_mode ? 0 : $urandom_range(0, 15);
      end
      if (!offering) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pend_elapsed_q.size() != 0) begin
          cur_elapsed = pend_elapsed_q.pop_front();
          offering = 1'b1;
        end
      end
      s_axis_tvalid <= offering;
      s_axis_tdata  <= {{(InTdataWidth-ElapsedWidth){1'b0}}, cur_elapsed};
    end
  end

  // output side: random backpressure and field compare
  always @(posedge clk_i or negedge rst_ni) begin
    cal_word_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (date_exp_q.size() == 0) begin
          $display("%0t: result word with nothing expected, actual %h", $time, m_axis_tdata);
          err_cnt++;
        end else begin
          want = date_exp_q.pop_front();
          check_field("cur_year",      want.year,   m_axis_tdata[13:0]);
          check_field("cur_month",     want.month,  m_axis_tdata[17:14]);
          check_field("cur_day",       want.day,    m_axis_tdata[22:18]);
          check_field("cur_hour",      want.hour,   m_axis_tdata[27:23]);
          check_field("cur_minute",    want.minute, m_axis_tdata[33:28]);
          check_field("minute_of_day", want.mod,    m_axis_tdata[44:34]);
          check_field("pad",           0,           m_axis_tdata[47:45]);
          n_checked++;
        end
        recv_gap = burst_mode ? 0 : $urandom_range(0, 15);
      end else if (recv_gap > 0) begin
        recv_gap--;
      end
      m_axis_tready <= !hold_off && (recv_gap == 0);
    end
  end

  // long receiver stall while the sender keeps offering
  initial begin
    wait (n_sent >= HOLD_AFTER);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset boot date, field extremes and hour/day boundaries
    pend_elapsed_q = '{17'd0, 17'd1, 17'd59, 17'd60, 17'd1439, 17'd1440,
                       17'(MAX_ELAPSED), 17'h1FFFF, 17'h0AAAA};
    wait_drained();

    // last boot year, rollover into the final year
    set_boot(YEAR_MAX_BOOT, MONTH_DEC, 31, HOUR_LAST, MINUTE_LAST);
    pend_elapsed_q = '{17'd1, 17'h1FFFF};
    wait_drained();

    // below-range boot values saturate up, hour and minute saturate down
    set_boot(0, 0, 0, 31, 63);
    pend_elapsed_q = '{17'd0, 17'd1};
    wait_drained();

    // above-range year and month, then writes to unused indexes
    set_boot(16383, 15, 31, 5, 30);
    pend_elapsed_q = '{17'd100000};
    wait_drained();
    for (int i = CFG_NONE_LO; i <= CFG_NONE_HI; i++) begin
      write_boot_reg(CfgIdxWidth'(i), '1);
    end
    pend_elapsed_q = '{17'h15555};
    wait_drained();

    // leap rules and day past the end of the boot month
    set_boot(2000, MONTH_FEB, 29, 0, 0);
    pend_elapsed_q = '{17'd1440};
    wait_drained();
    set_boot(1900, MONTH_FEB, 30, 12, 0);
    pend_elapsed_q = '{17'd720};
    wait_drained();
    set_boot(2024, MONTH_FEB, 28, HOUR_LAST, MINUTE_LAST);
    pend_elapsed_q = '{17'd1};
    wait_drained();
    set_boot(2023, 4, 31, 0, 0);
    pend_elapsed_q = '{17'd1440};
    wait_drained();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      burst_mode = (ph == 2);
      if ($urandom_range(0, 4) == 0) begin
        set_boot($urandom() & 14'h3FFF, $urandom() & 14'h3FFF, $urandom() & 14'h3FFF,
                 $urandom() & 14'h3FFF, $urandom() & 14'h3FFF);
      end else begin
        set_boot($urandom_range(1, YEAR_MAX_BOOT), $urandom_range(1, 12),
                 $urandom_range(1, 31), $urandom_range(0, HOUR_LAST),
                 $urandom_range(0, MINUTE_LAST));
      end
      if ($urandom_range(0, 1) == 1) begin
        write_boot_reg(CfgIdxWidth'($urandom_range(CFG_NONE_LO, CFG_NONE_HI)),
                       CfgDataWidth'($urandom()));
      end
      repeat (PHASE_WORDS) pend_elapsed_q.push_back(draw_elapsed());
      wait_drained();
    end
    burst_mode = 1'b0;

    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("run covered %0d input words and %0d checked result words", n_sent, n_checked);
    $display("over %0d boot settings plus reset defaults, %0d mismatches", n_settings,
             err_cnt);
    if (err_cnt == 0 && date_exp_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ calendar_minute_advance_core.f @@
rtl/cma_pkg.sv
rtl/cma_ctrl.sv
rtl/cma_dp.sv
rtl/calendar_minute_advance_core.sv
dv/tb_calendar_minute_advance_core.sv
